FILE: sv/cau_pkg.sv
`timescale 1ns / 1ps

package cau_pkg;

  // Quotient bits resolved by the division cells; a quotient of 2^33 or
  // more saturates and is caught before the first cell.
  localparam int unsigned NQ = 33;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cau_cmd_e;

  typedef struct packed {
    cau_cmd_e           cmd;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } cau_in_t;

  typedef struct packed {
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic               im_positive;
    logic               overflow;
    logic               div_zero;
  } cau_out_t;

  // Data carried from cell to cell through the division chain.
  typedef struct packed {
    logic [63:0]    den;
    logic [63:0]    rem_re;
    logic [63:0]    rem_im;
    logic [NQ-1:0]  dvd_re;
    logic [NQ-1:0]  dvd_im;
    logic [NQ-1:0]  q_re;
    logic [NQ-1:0]  q_im;
    logic           neg_re;
    logic           neg_im;
    logic           huge_re;
    logic           huge_im;
    logic           dz;
    logic           is_div;
    logic [31:0]    fr_re;
    logic [31:0]    fr_im;
    logic           fr_ovf;
  } cau_cell_t;

  // Sign and magnitude to a saturated 32-bit word; returns {overflow, word}.
  function automatic logic [32:0] cau_sat(logic neg, logic huge, logic [34:0] mag);
    logic [34:0] nm;
    nm = 35'd0 - mag;
    if (neg) begin
      if (huge || mag > 35'h080000000) begin
        return {1'b1, 32'h80000000};
      end
      return {1'b0, nm[31:0]};
    end
    if (huge || mag > 35'h07FFFFFFF) begin
      return {1'b1, 32'h7FFFFFFF};
    end
    return {1'b0, mag[31:0]};
  endfunction

endpackage

FILE: sv/complex_arith_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                Payload
// in        request    in_valid_i / in_stall_o  in_data_i  (cau_in_t)
// out       result     out_valid_o / out_stall_i out_data_o (cau_out_t)
//
// One request is taken per cycle while in_stall_o is low; it then passes through
// the input register, three front stages (multiply, sum, prepare), the 33-cell
// division chain and the output register before its result is shown.
// Every stage loads when it is empty or its successor loads, so bubbles close
// up and requests keep entering while a result waits on a stalled output, until every stage is full.
// Reset clears only the valid bits of the stages.

module complex_arith_unit import cau_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  cau_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output cau_out_t out_data_o
);

  localparam int unsigned DW = 64 + FRAC_BITS;
  localparam logic [64:0] Half = (65'd1 << FRAC_BITS) >> 1;

  typedef struct packed {
    cau_cmd_e           cmd;
    logic signed [63:0] p_ac;
    logic signed [63:0] p_bd;
    logic signed [63:0] p_ad;
    logic signed [63:0] p_bc;
    logic [63:0]        p_cc;
    logic [63:0]        p_dd;
    logic [31:0]        as_re;
    logic [31:0]        as_im;
    logic               as_ovf;
  } cau_prod_t;

  typedef struct packed {
    cau_cmd_e           cmd;
    logic signed [64:0] s_re;
    logic signed [64:0] s_im;
    logic [63:0]        den;
    logic [31:0]        as_re;
    logic [31:0]        as_im;
    logic               as_ovf;
  } cau_sum_t;

  // Stage 1: input register
  logic      v1_q;
  cau_in_t   in_q;
  // Stage 2: products
  logic      v2_q;
  cau_prod_t prod_q, prod_d;
  // Stage 3: sums
  logic      v3_q;
  cau_sum_t  sum_q, sum_d;
  // Stage 4: chain entry
  logic      v4_q;
  cau_cell_t prep_q, prep_d;

  logic      en1, en2, en3, en4, en_out;

  logic [NQ-1:0] cell_v;
  logic [NQ-1:0] cell_rdy;
  cau_cell_t     cell_d [NQ];

  logic     out_v_q;
  cau_out_t out_q, out_d;

  assign en_out     = !out_v_q || !out_stall_i;
  assign en4        = !v4_q || cell_rdy[0];
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_stall_o = !en1;

  // Products, and the add and subtract results, which need no more work.
  always_comb begin
    logic signed [32:0] sr, si;
    logic [32:0]        mr, mi;
    logic [32:0]        rr, ri;
    if (in_q.cmd == CMD_SUB) begin
      sr = 33'(in_q.a_re) - 33'(in_q.b_re);
      si = 33'(in_q.a_im) - 33'(in_q.b_im);
    end else begin
      sr = 33'(in_q.a_re) + 33'(in_q.b_re);
      si = 33'(in_q.a_im) + 33'(in_q.b_im);
    end
    mr = sr[32] ? 33'(-sr) : 33'(sr);
    mi = si[32] ? 33'(-si) : 33'(si);
    rr = cau_sat(sr[32], 1'b0, {2'b00, mr});
    ri = cau_sat(si[32], 1'b0, {2'b00, mi});
    prod_d.cmd    = in_q.cmd;
    prod_d.p_ac   = in_q.a_re * in_q.b_re;
    prod_d.p_bd   = in_q.a_im * in_q.b_im;
    prod_d.p_ad   = in_q.a_re * in_q.b_im;
    prod_d.p_bc   = in_q.a_im * in_q.b_re;
    prod_d.p_cc   = 64'(in_q.b_re * in_q.b_re);
    prod_d.p_dd   = 64'(in_q.b_im * in_q.b_im);
    prod_d.as_re  = rr[31:0];
    prod_d.as_im  = ri[31:0];
    prod_d.as_ovf = rr[32] | ri[32];
  end

  always_comb begin
    logic signed [64:0] ac, bd, ad, bc;
    ac = 65'(prod_q.p_ac);
    bd = 65'(prod_q.p_bd);
    ad = 65'(prod_q.p_ad);
    bc = 65'(prod_q.p_bc);
    sum_d.cmd    = prod_q.cmd;
    sum_d.den    = prod_q.p_cc + prod_q.p_dd;
    sum_d.as_re  = prod_q.as_re;
    sum_d.as_im  = prod_q.as_im;
    sum_d.as_ovf = prod_q.as_ovf;
    if (prod_q.cmd == CMD_DIV) begin
      sum_d.s_re = ac + bd;
      sum_d.s_im = bc - ad;
    end else begin
      sum_d.s_re = ac - bd;
      sum_d.s_im = ad + bc;
    end
  end

  // Rounds a multiply part, passes add and subtract results on, and sets up the dividends for a divide.
  always_comb begin
    logic [64:0]    mag_re, mag_im, m_re, m_im;
    logic [32:0]    nr, ni;
    logic [DW-1:0]  full_re, full_im;
    mag_re  = sum_q.s_re[64] ? 65'(-sum_q.s_re) : 65'(sum_q.s_re);
    mag_im  = sum_q.s_im[64] ? 65'(-sum_q.s_im) : 65'(sum_q.s_im);
    m_re    = (mag_re + Half) >> FRAC_BITS;
    m_im    = (mag_im + Half) >> FRAC_BITS;
    nr      = cau_sat(sum_q.s_re[64], |m_re[64:35], m_re[34:0]);
    ni      = cau_sat(sum_q.s_im[64], |m_im[64:35], m_im[34:0]);
    full_re = DW'(mag_re[63:0]) << FRAC_BITS;
    full_im = DW'(mag_im[63:0]) << FRAC_BITS;
    prep_d.den     = sum_q.den;
    prep_d.rem_re  = 64'(full_re >> NQ);
    prep_d.rem_im  = 64'(full_im >> NQ);
    prep_d.dvd_re  = full_re[NQ-1:0];
    prep_d.dvd_im  = full_im[NQ-1:0];
    prep_d.q_re    = '0;
    prep_d.q_im    = '0;
    prep_d.neg_re  = sum_q.s_re[64];
    prep_d.neg_im  = sum_q.s_im[64];
    prep_d.huge_re = 64'(full_re >> NQ) >= sum_q.den;
    prep_d.huge_im = 64'(full_im >> NQ) >= sum_q.den;
    prep_d.dz      = sum_q.den == 64'd0;
    prep_d.is_div  = sum_q.cmd == CMD_DIV;
    if (sum_q.cmd == CMD_MUL) begin
      prep_d.fr_re  = nr[31:0];
      prep_d.fr_im  = ni[31:0];
      prep_d.fr_ovf = nr[32] | ni[32];
    end else begin
      prep_d.fr_re  = sum_q.as_re;
      prep_d.fr_im  = sum_q.as_im;
      prep_d.fr_ovf = sum_q.as_ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
      if (en_out) begin
        out_v_q <= cell_v[NQ-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      in_q <= in_data_i;
    end
    if (en2) begin
      prod_q <= prod_d;
    end
    if (en3) begin
      sum_q <= sum_d;
    end
    if (en4) begin
      prep_q <= prep_d;
    end
    if (en_out) begin
      out_q <= out_d;
    end
  end

  for (genvar k = 0; k < NQ; k++) begin : g_cell
    if (k == 0) begin : g_first
      cau_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .valid_i (v4_q),
        .data_i  (prep_q),
        .ready_o (cell_rdy[k]),
        .ready_i ((k == NQ - 1) ? en_out : cell_rdy[(k + 1) % NQ]),
        .valid_o (cell_v[k]),
        .data_o  (cell_d[k])
      );
    end else begin : g_next
      cau_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .valid_i (cell_v[k-1]),
        .data_i  (cell_d[k-1]),
        .ready_o (cell_rdy[k]),
        .ready_i ((k == NQ - 1) ? en_out : cell_rdy[(k + 1) % NQ]),
        .valid_o (cell_v[k]),
        .data_o  (cell_d[k])
      );
    end
  end

  // Round the quotients to nearest, ties away from zero, then saturate; other commands keep their result.
  always_comb begin
    cau_cell_t   c;
    logic        up_re, up_im;
    logic [34:0] qr_re, qr_im;
    logic [32:0] fre, fim;
    logic [31:0] re, im;
    logic        ovf;
    c     = cell_d[NQ-1];
    up_re = c.rem_re >= (c.den - c.rem_re);
    up_im = c.rem_im >= (c.den - c.rem_im);
    qr_re = {2'b00, c.q_re} + {34'd0, up_re};
    qr_im = {2'b00, c.q_im} + {34'd0, up_im};
    fre   = cau_sat(c.neg_re, c.huge_re, qr_re);
    fim   = cau_sat(c.neg_im, c.huge_im, qr_im);
    if (!c.is_div) begin
      re  = c.fr_re;
      im  = c.fr_im;
      ovf = c.fr_ovf;
    end else if (c.dz) begin
      re  = '0;
      im  = '0;
      ovf = 1'b0;
    end else begin
      re  = fre[31:0];
      im  = fim[31:0];
      ovf = fre[32] | fim[32];
    end
    out_d.res_re      = re;
    out_d.res_im      = im;
    out_d.im_positive = !im[31] && (im != 32'd0);
    out_d.overflow    = ovf;
    out_d.div_zero    = c.is_div && c.dz;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.div_zero |->
      out_q.res_re == 32'sd0 && out_q.res_im == 32'sd0 && !out_q.overflow)
    else $error("divide by zero result is not clean");

  a_im_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> out_q.im_positive == (!out_q.res_im[31] && out_q.res_im != 32'sd0))
    else $error("imaginary sign flag disagrees with result");

  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.overflow |->
      out_q.res_re == 32'h7FFFFFFF || out_q.res_re == 32'h80000000 ||
      out_q.res_im == 32'h7FFFFFFF || out_q.res_im == 32'h80000000)
    else $error("overflow flag without a saturated part");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(cell_v[NQ-1]))
    else $error("result appeared without a request in the last cell");
`endif

endmodule

FILE: sv/cau_cell.sv
`timescale 1ns / 1ps

module cau_cell import cau_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  cau_cell_t data_i,
  output logic      ready_o,
  input  logic      ready_i,
  output logic      valid_o,
  output cau_cell_t data_o
);

  logic      valid_q;
  cau_cell_t data_q;
  cau_cell_t data_d;
  logic [64:0] r2_re, r2_im;
  logic        ge_re, ge_im;

  assign ready_o = !valid_q || ready_i;

  // One restoring division step for each lane, sharing the divisor.
  always_comb begin
    r2_re  = {data_i.rem_re, data_i.dvd_re[NQ-1]};
    r2_im  = {data_i.rem_im, data_i.dvd_im[NQ-1]};
    ge_re  = r2_re >= {1'b0, data_i.den};
    ge_im  = r2_im >= {1'b0, data_i.den};
    data_d = data_i;
    data_d.rem_re = ge_re ? 64'(r2_re - {1'b0, data_i.den}) : r2_re[63:0];
    data_d.rem_im = ge_im ? 64'(r2_im - {1'b0, data_i.den}) : r2_im[63:0];
    data_d.dvd_re = {data_i.dvd_re[NQ-2:0], 1'b0};
    data_d.dvd_im = {data_i.dvd_im[NQ-2:0], 1'b0};
    data_d.q_re   = {data_i.q_re[NQ-2:0], ge_re};
    data_d.q_im   = {data_i.q_im[NQ-2:0], ge_im};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
